// ----- rtl/pcmr_pkg.sv -----
`default_nettype none
package pcmr_pkg;

    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int ANG_W    = 9;
    localparam int RAD_W    = 10;
    localparam int VAL_W    = 8;
    localparam int LEN_W    = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int ANGLE_ROWS = 360;
    localparam int MAX_RADIUS = 1024;
    localparam int QUAD_DEG   = 90;
    localparam int HALF_DEG   = 180;
    localparam int MEM_DEPTH  = ANGLE_ROWS * MAX_RADIUS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    localparam int DX_W   = 11;
    localparam int DY_W   = 10;
    localparam int UV_W   = 10;
    localparam int SQ1_W  = 20;
    localparam int SQ_W   = 21;
    localparam int ROOT_W = 21;
    localparam int R_W    = 11;
    localparam int K_W    = 7;

    localparam int ROM_FRAC = 50;
    localparam int ROM_W    = ROM_FRAC + 1;
    localparam int PROD_W   = ROM_W + UV_W;

    localparam int ANGLE_STEPS = 7;
    localparam int SQRT_STEPS  = 11;
    localparam int SQRT_FIRST  = 3;
    localparam int GEO_STAGES  = SQRT_FIRST + SQRT_STEPS + 1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIX_X   = 2'd0,
        CFG_FIX_Y   = 2'd1,
        CFG_ROW_LEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [X_W-1:0]   px;
        logic [Y_W-1:0]   py;
        logic [ANG_W-1:0] ang;
        logic [RAD_W-1:0] rad;
        logic [VAL_W-1:0] val;
    } t_item;

    typedef struct packed {
        t_item            item;
        logic [ANG_W-1:0] a;
        logic [R_W-1:0]   r;
    } t_geo_out;

    typedef logic [ROM_W-1:0] t_rom [0:QUAD_DEG-1];

    function automatic t_rom build_rom(bit want_cos);
        t_rom rom;
        real  rad;
        real  f;
        for (int k = 0; k < QUAD_DEG; k++) begin
            rad = k * 3.14159265358979323846 / HALF_DEG;
            f = want_cos ? $cos(rad) : $sin(rad);
            rom[k] = ROM_W'(longint'(f * (2.0 ** ROM_FRAC)));
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom(1'b0);
    localparam t_rom COS_ROM = build_rom(1'b1);

endpackage
`default_nettype wire

// ----- rtl/pcmr_in_if.sv -----
`default_nettype none
interface pcmr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [pcmr_pkg::X_W-1:0]    pixel_x;
    logic [pcmr_pkg::Y_W-1:0]    pixel_y;
    logic [pcmr_pkg::ANG_W-1:0]  angle_index;
    logic [pcmr_pkg::RAD_W-1:0]  radius_index;
    logic [pcmr_pkg::VAL_W-1:0]  entry_value;

    modport source (output valid, opcode, pixel_x, pixel_y, angle_index, radius_index,
                    entry_value, input ready);
    modport sink (input valid, opcode, pixel_x, pixel_y, angle_index, radius_index,
                  entry_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcmr_out_if.sv -----
`default_nettype none
interface pcmr_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcmr_pkg::VAL_W-1:0]  mask_value;
    logic                        radius_overflow;
    logic [pcmr_pkg::X_W-1:0]    echo_x;
    logic [pcmr_pkg::Y_W-1:0]    echo_y;

    modport source (output valid, mask_value, radius_overflow, echo_x, echo_y, input ready);
    modport sink (input valid, mask_value, radius_overflow, echo_x, echo_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcmr_geom.sv -----
`default_nettype none
module pcmr_geom (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire pcmr_pkg::t_item           i_item,
    input  wire logic [pcmr_pkg::X_W-1:0]  i_fix_x,
    input  wire logic [pcmr_pkg::Y_W-1:0]  i_fix_y,
    output pcmr_pkg::t_geo_out             o_geo
);

    typedef struct packed {
        pcmr_pkg::t_item                    item;
        logic signed [pcmr_pkg::DX_W-1:0]   dx;
        logic signed [pcmr_pkg::DY_W-1:0]   dy;
        logic [pcmr_pkg::UV_W-1:0]          u;
        logic [pcmr_pkg::UV_W-1:0]          v;
        logic [1:0]                         quad;
        logic                               zero;
        logic [pcmr_pkg::SQ1_W-1:0]         sqx;
        logic [pcmr_pkg::SQ1_W-1:0]         sqy;
        logic [pcmr_pkg::SQ_W-1:0]          rem;
        logic [pcmr_pkg::ROOT_W-1:0]        root;
        logic [pcmr_pkg::K_W-1:0]           k;
        logic [pcmr_pkg::ANG_W-1:0]         a;
    } t_stage;

    t_stage r_st [0:pcmr_pkg::GEO_STAGES-1];
    t_stage n_st [0:pcmr_pkg::GEO_STAGES-1];

    function automatic logic [pcmr_pkg::SQ1_W-1:0] square(
        logic signed [pcmr_pkg::DX_W-1:0] d);
        logic signed [2*pcmr_pkg::DX_W-1:0] w;
        w = (2*pcmr_pkg::DX_W)'(d);
        return pcmr_pkg::SQ1_W'(w * w);
    endfunction

    // one bisection step on the degree inside the quadrant
    function automatic logic [pcmr_pkg::K_W-1:0] angle_step(
        logic [pcmr_pkg::K_W-1:0] k, logic [pcmr_pkg::K_W:0] step,
        logic [pcmr_pkg::UV_W-1:0] u, logic [pcmr_pkg::UV_W-1:0] v);
        logic [pcmr_pkg::K_W:0]     cand;
        logic [pcmr_pkg::K_W-1:0]   idx;
        logic [pcmr_pkg::PROD_W-1:0] lhs;
        logic [pcmr_pkg::PROD_W-1:0] rhs;
        logic                       in_rng;
        logic                       reached;
        cand    = {1'b0, k} + step;
        in_rng  = cand < (pcmr_pkg::K_W+1)'(pcmr_pkg::QUAD_DEG);
        idx     = in_rng ? cand[pcmr_pkg::K_W-1:0] : '0;
        lhs     = pcmr_pkg::PROD_W'(v) * pcmr_pkg::PROD_W'(pcmr_pkg::COS_ROM[idx]);
        rhs     = pcmr_pkg::PROD_W'(u) * pcmr_pkg::PROD_W'(pcmr_pkg::SIN_ROM[idx]);
        // the diagonal is tested exactly
        if (cand == (pcmr_pkg::K_W+1)'(pcmr_pkg::QUAD_DEG / 2)) begin
            reached = (v >= u);
        end else begin
            reached = (lhs >= rhs);
        end
        return (in_rng && reached) ? cand[pcmr_pkg::K_W-1:0] : k;
    endfunction

    always_comb begin
        logic signed [pcmr_pkg::DX_W:0] su;
        logic signed [pcmr_pkg::DX_W:0] sv;
        logic signed [pcmr_pkg::DX_W:0] tu;
        logic signed [pcmr_pkg::DX_W:0] tv;
        logic [pcmr_pkg::ROOT_W:0]      sum;
        logic [pcmr_pkg::ROOT_W-1:0]    bitv;

        // first stage: offsets from fixation and quadrant fold
        n_st[0]      = r_st[0];
        n_st[0].item = i_item;
        n_st[0].dx   = $signed({1'b0, i_item.px}) - $signed({1'b0, i_fix_x});
        n_st[0].dy   = $signed({1'b0, i_item.py}) - $signed({1'b0, i_fix_y});
        su = (pcmr_pkg::DX_W+1)'(n_st[0].dx);
        sv = -(pcmr_pkg::DX_W+1)'(n_st[0].dy);
        if (su > 0 && sv >= 0) begin
            tu = su; tv = sv; n_st[0].quad = 2'd0;
        end else if (su <= 0 && sv > 0) begin
            tu = sv; tv = -su; n_st[0].quad = 2'd1;
        end else if (su < 0 && sv <= 0) begin
            tu = -su; tv = -sv; n_st[0].quad = 2'd2;
        end else begin
            tu = -sv; tv = su; n_st[0].quad = 2'd3;
        end
        n_st[0].u    = tu[pcmr_pkg::UV_W-1:0];
        n_st[0].v    = tv[pcmr_pkg::UV_W-1:0];
        n_st[0].zero = (su == 0) && (sv == 0);
        n_st[0].k    = '0;

        for (int i = 1; i < pcmr_pkg::GEO_STAGES; i++) begin
            n_st[i] = r_st[i-1];
            if (i <= pcmr_pkg::ANGLE_STEPS) begin
                n_st[i].k = angle_step(r_st[i-1].k,
                    (pcmr_pkg::K_W+1)'(1 << (pcmr_pkg::ANGLE_STEPS - i)),
                    r_st[i-1].u, r_st[i-1].v);
            end
            if (i == 1) begin
                n_st[i].sqx = square(r_st[i-1].dx);
                n_st[i].sqy = square(pcmr_pkg::DX_W'(r_st[i-1].dy));
            end
            if (i == 2) begin
                n_st[i].rem  = pcmr_pkg::SQ_W'(r_st[i-1].sqx) + pcmr_pkg::SQ_W'(r_st[i-1].sqy);
                n_st[i].root = '0;
            end
            if (i >= pcmr_pkg::SQRT_FIRST && i < pcmr_pkg::SQRT_FIRST + pcmr_pkg::SQRT_STEPS)
            begin
                // digit-by-digit root, one bit pair per stage
                bitv = pcmr_pkg::ROOT_W'(1) <<
                       (2 * (pcmr_pkg::SQRT_STEPS - 1 - (i - pcmr_pkg::SQRT_FIRST)));
                sum  = (pcmr_pkg::ROOT_W+1)'(r_st[i-1].root) + (pcmr_pkg::ROOT_W+1)'(bitv);
                if ((pcmr_pkg::ROOT_W+1)'(r_st[i-1].rem) >= sum) begin
                    n_st[i].rem  = pcmr_pkg::SQ_W'((pcmr_pkg::ROOT_W+1)'(r_st[i-1].rem) - sum);
                    n_st[i].root = (r_st[i-1].root >> 1) + bitv;
                end else begin
                    n_st[i].root = r_st[i-1].root >> 1;
                end
            end
            if (i == pcmr_pkg::GEO_STAGES - 1) begin
                n_st[i].a = r_st[i-1].zero ? '0 :
                    pcmr_pkg::ANG_W'(r_st[i-1].quad) * pcmr_pkg::ANG_W'(pcmr_pkg::QUAD_DEG)
                    + pcmr_pkg::ANG_W'(r_st[i-1].k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcmr_pkg::GEO_STAGES; i++) begin
                r_st[i].item.valid <= 1'b0;
            end
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_geo.item = r_st[pcmr_pkg::GEO_STAGES-1].item;
    assign o_geo.a    = r_st[pcmr_pkg::GEO_STAGES-1].a;
    assign o_geo.r    = r_st[pcmr_pkg::GEO_STAGES-1].root[pcmr_pkg::R_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/polar_to_cartesian_mask_remap.sv -----
// Polar mask remap: write transactions (opcode 0) store one byte of a 360 x 1024
// polar mask at angle*row_length+radius; lookup transactions (opcode 1) return
// the byte for a cartesian pixel, using the exact floor of the distance to the
// fixation point as radius and the floor of the angle in degrees (counter-
// clockwise, image y downward) as row. One transaction is taken every cycle
// unless the input stalls; a lookup result passes the fold, square, sum and
// angle stages around the 11-stage square root, then the address, memory and
// output stages. Writes and lookups flow through the same pipeline in order,
// so a lookup always sees every earlier write. Unwritten mask entries read as
// garbage. The input stalls only when the result register is held and the
// stage in front of it holds a lookup. The user writes configuration only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module polar_to_cartesian_mask_remap (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    pcmr_in_if.sink                               i_item,
    pcmr_out_if.source                            o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [pcmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pcmr_pkg::CFG_W-1:0]       i_cfg_data
);

    // address stage
    typedef struct packed {
        logic                        valid;
        pcmr_pkg::t_op               op;
        logic                        ovf;
        logic                        wr;
        logic [pcmr_pkg::ADDR_W-1:0] addr;
        logic [pcmr_pkg::VAL_W-1:0]  val;
        logic [pcmr_pkg::X_W-1:0]    px;
        logic [pcmr_pkg::Y_W-1:0]    py;
    } t_addr_stage;

    // config registers
    logic [pcmr_pkg::X_W-1:0]   r_fix_x;
    logic [pcmr_pkg::Y_W-1:0]   r_fix_y;
    logic [pcmr_pkg::LEN_W-1:0] r_row_len;
    logic [pcmr_pkg::LEN_W-1:0] len;

    pcmr_pkg::t_item    in_item;
    pcmr_pkg::t_geo_out geo;
    logic               en;
    logic               out_free;

    t_addr_stage r_a;
    t_addr_stage n_a;
    t_addr_stage r_b;

    // polar mask storage, one read and at most one write per enabled cycle
    logic [pcmr_pkg::VAL_W-1:0] mem [0:pcmr_pkg::MEM_DEPTH-1];
    logic [pcmr_pkg::VAL_W-1:0] r_rd_data;

    logic                        r_out_valid;
    logic [pcmr_pkg::VAL_W-1:0]  r_out_mask;
    logic                        r_out_ovf;
    logic [pcmr_pkg::X_W-1:0]    r_out_x;
    logic [pcmr_pkg::Y_W-1:0]    r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_x   <= '0;
            r_fix_y   <= '0;
            r_row_len <= pcmr_pkg::LEN_W'(pcmr_pkg::MAX_RADIUS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcmr_pkg::CFG_FIX_X:   r_fix_x   <= i_cfg_data[pcmr_pkg::X_W-1:0];
                pcmr_pkg::CFG_FIX_Y:   r_fix_y   <= i_cfg_data[pcmr_pkg::Y_W-1:0];
                pcmr_pkg::CFG_ROW_LEN: r_row_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a row length above the mask width acts as the full width
    assign len = (r_row_len > pcmr_pkg::LEN_W'(pcmr_pkg::MAX_RADIUS)) ?
                 pcmr_pkg::LEN_W'(pcmr_pkg::MAX_RADIUS) : r_row_len;

    // pipeline moves unless a held result would be overwritten
    assign out_free = !r_out_valid || o_result.ready;
    assign en       = out_free || !(r_b.valid && r_b.op == pcmr_pkg::OP_LOOKUP);
    assign i_item.ready = en;

    always_comb begin
        in_item.valid = i_item.valid;
        in_item.op    = pcmr_pkg::t_op'(i_item.opcode);
        in_item.px    = i_item.pixel_x;
        in_item.py    = i_item.pixel_y;
        in_item.ang   = i_item.angle_index;
        in_item.rad   = i_item.radius_index;
        in_item.val   = i_item.entry_value;
    end

    pcmr_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (in_item),
        .i_fix_x (r_fix_x),
        .i_fix_y (r_fix_y),
        .o_geo   (geo)
    );

    // address: row * row_length + column, writes and lookups share it
    always_comb begin
        logic [pcmr_pkg::ANG_W-1:0]         row;
        logic [pcmr_pkg::R_W-1:0]           col;
        logic [pcmr_pkg::ANG_W+pcmr_pkg::LEN_W-1:0] prod;
        logic                               is_lookup;
        is_lookup = (geo.item.op == pcmr_pkg::OP_LOOKUP);
        row  = is_lookup ? geo.a : geo.item.ang;
        col  = is_lookup ? geo.r : pcmr_pkg::R_W'(geo.item.rad);
        prod = (pcmr_pkg::ANG_W+pcmr_pkg::LEN_W)'(row) *
               (pcmr_pkg::ANG_W+pcmr_pkg::LEN_W)'(len)
               + (pcmr_pkg::ANG_W+pcmr_pkg::LEN_W)'(col);
        n_a.valid = geo.item.valid;
        n_a.op    = geo.item.op;
        n_a.ovf   = geo.r >= len;
        // out-of-range writes are dropped
        n_a.wr    = geo.item.valid && !is_lookup
                    && (geo.item.ang < pcmr_pkg::ANG_W'(pcmr_pkg::ANGLE_ROWS))
                    && (pcmr_pkg::LEN_W'(geo.item.rad) < len);
        n_a.addr  = prod[pcmr_pkg::ADDR_W-1:0];
        n_a.val   = geo.item.val;
        n_a.px    = geo.item.px;
        n_a.py    = geo.item.py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_a.wr    <= 1'b0;
            r_b.valid <= 1'b0;
        end else if (en) begin
            r_a <= n_a;
            r_b <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a.wr) begin
                mem[r_a.addr] <= r_a.val;
            end
            r_rd_data <= mem[r_a.addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b.valid && (r_b.op == pcmr_pkg::OP_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_mask <= r_b.ovf ? '0 : r_rd_data;
            r_out_ovf  <= r_b.ovf;
            r_out_x    <= r_b.px;
            r_out_y    <= r_b.py;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.mask_value      = r_out_mask;
    assign o_result.radius_overflow = r_out_ovf;
    assign o_result.echo_x          = r_out_x;
    assign o_result.echo_y          = r_out_y;

endmodule
`default_nettype wire
